>>> rtl/ffaa_pkg.sv
// Shared types and constants of the first-fit arena allocator.
`default_nettype none
package ffaa_pkg;

    localparam int ADDR_W    = 48;
    localparam int ID_W      = 32;
    localparam int PADDR_W   = 5;
    localparam int PDATA_W   = 64;
    localparam int ALIGN_W   = 5;
    localparam int STATUS_W  = 4;
    localparam int FUNC_W    = 3;

    localparam logic [ALIGN_W-1:0] ALIGN_MIN = 5'd3;
    localparam logic [ALIGN_W-1:0] ALIGN_MAX = 5'd20;
    localparam logic [ADDR_W-1:0]  ARENA_SIZE_RST = 48'd1048576;

    // register index, taken from paddr[4:3]
    localparam logic [1:0] REG_ARENA_BASE = 2'd0;
    localparam logic [1:0] REG_ARENA_SIZE = 2'd1;
    localparam logic [1:0] REG_ALIGN_LOG2 = 2'd2;

    // request functions
    localparam logic [FUNC_W-1:0] FN_ALLOC = 3'd0;
    localparam logic [FUNC_W-1:0] FN_FREE  = 3'd1;
    localparam logic [FUNC_W-1:0] FN_PIN   = 3'd2;
    localparam logic [FUNC_W-1:0] FN_UNPIN = 3'd3;
    localparam logic [FUNC_W-1:0] FN_SEAL  = 3'd4;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK           = 4'd0,
        ST_TOO_LARGE    = 4'd1,
        ST_EXHAUSTED    = 4'd2,
        ST_ID_EXHAUSTED = 4'd3,
        ST_UNKNOWN      = 4'd4,
        ST_READ_ONLY    = 4'd5,
        ST_PINNED       = 4'd6,
        ST_TABLE_FULL   = 4'd7,
        ST_PIN_OVERFLOW = 4'd8,
        ST_NOT_PINNED   = 4'd9
    } status_t;

    // one free range
    typedef struct packed {
        logic [ADDR_W-1:0] base;
        logic [ADDR_W-1:0] size;
    } free_ent_t;

endpackage
`default_nettype wire

>>> rtl/first_fit_arena_allocator.sv
// First-fit arena allocator: request sequencer, free list and live table memories.
//
// Hands out aligned ranges from one arena. Requests arrive as words on the req channel and
// each gives exactly one result word on the rsp channel; one request is worked at a time.
// Latency is set by the single-port scans over the two memories: allocate walks the free
// list to the first range that fits, then the live table to the lowest empty slot, and moves
// later free ranges down when a range is used up; free, pin, unpin and seal look the id up in
// the live table, and free also walks the free list and moves ranges to merge or insert.
// A new request is taken while the previous result still waits in the output register.
// Writing arena_base or arena_size reinitialises the arena with no clearing pass; the user
// must write configuration only while the block is idle; the block itself does not enforce
// this.
`default_nettype none
module first_fit_arena_allocator
    import ffaa_pkg::*;
#(
    parameter int MAX_FREE = 16,
    parameter int MAX_LIVE = 16,
    parameter int PIN_BITS = 16
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    // configuration
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [PADDR_W-1:0]  paddr,
    input  wire logic [PDATA_W-1:0]  pwdata,
    output logic      [PDATA_W-1:0]  prdata,
    output logic                     pready,
    // request channel
    input  wire logic                req_valid,
    output logic                     req_stall,
    input  wire logic [FUNC_W-1:0]   func,
    input  wire logic [ADDR_W-1:0]   req_bytes,
    input  wire logic                writable_flag,
    input  wire logic                pin_for_write,
    input  wire logic [ID_W-1:0]     alloc_id,
    // result channel
    output logic                     rsp_valid,
    input  wire logic                rsp_stall,
    output logic [STATUS_W-1:0]      status,
    output logic [ID_W-1:0]          result_id,
    output logic [ADDR_W-1:0]        result_base,
    output logic [ADDR_W-1:0]        result_reserved,
    output logic [ADDR_W-1:0]        live_total,
    output logic [ADDR_W-1:0]        reserved_total,
    output logic [ADDR_W-1:0]        peak_total
);

    localparam int FI_W = (MAX_FREE > 1) ? $clog2(MAX_FREE) : 1;
    localparam int FC_W = $clog2(MAX_FREE + 1);
    localparam int LI_W = (MAX_LIVE > 1) ? $clog2(MAX_LIVE) : 1;
    localparam int LC_W = $clog2(MAX_LIVE + 1);

    typedef struct packed {
        logic [ID_W-1:0]     ident;
        logic [ADDR_W-1:0]   start;
        logic [ADDR_W-1:0]   logical;
        logic [ADDR_W-1:0]   reserved;
        logic [PIN_BITS-1:0] pin;
        logic                writable;
    } live_ent_t;

    typedef enum logic [4:0] {
        S_IDLE, S_NEED, S_ACHK, S_AF_RD, S_AF_CHK, S_SLOT, S_ACOMMIT, S_PEAK,
        S_SHD_RD, S_SHD_WR, S_LK_RD, S_LK_CHK, S_OP, S_FR_RD, S_FR_CHK,
        S_FR_MERGE, S_FR_ACT, S_FR_SUM2, S_SHU_RD, S_SHU_WR, S_FR_INS, S_DONE
    } state_t;

    state_t state_reg;

    // configuration registers
    logic [ADDR_W-1:0]  arena_base_reg;
    logic [ADDR_W-1:0]  arena_size_reg;
    logic [ALIGN_W-1:0] align_log2_reg;

    // allocator state
    logic [FC_W-1:0]     count_reg;
    logic [MAX_LIVE-1:0] live_valid_reg;
    logic [ID_W-1:0]     next_ident_reg;
    logic [ADDR_W-1:0]   sum_logical_reg;
    logic [ADDR_W-1:0]   sum_reserved_reg;
    logic [ADDR_W-1:0]   peak_reg;
    logic                fresh_reg;      // free entry 0 still reads as the whole arena

    // request word held while it is worked
    logic [FUNC_W-1:0] func_reg;
    logic [ADDR_W-1:0] req_bytes_reg;
    logic              wr_reg;
    logic              pw_reg;
    logic [ID_W-1:0]   aid_reg;

    // working registers
    logic [ADDR_W-1:0] need_reg;         // rounded size; merge sum on free
    logic [FC_W-1:0]   idx_reg;
    logic [FC_W-1:0]   jdx_reg;
    logic [LC_W-1:0]   lidx_reg;
    free_ent_t         cur_reg;
    free_ent_t         prev_reg;
    live_ent_t         ent_reg;
    logic              mp_reg;
    logic              mn_reg;
    status_t           res_status_reg;
    logic [ID_W-1:0]   res_id_reg;
    logic [ADDR_W-1:0] res_base_reg;
    logic [ADDR_W-1:0] res_reserved_reg;

    // output register
    logic              out_valid_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic [ID_W-1:0]   out_id_reg;
    logic [ADDR_W-1:0] out_base_reg;
    logic [ADDR_W-1:0] out_reserved_reg;
    logic [ADDR_W-1:0] out_live_reg;
    logic [ADDR_W-1:0] out_rsv_reg;
    logic [ADDR_W-1:0] out_peak_reg;

    // memories
    free_ent_t free_mem [MAX_FREE];
    live_ent_t live_mem [MAX_LIVE];
    free_ent_t fm_rdata_reg;
    logic      fm_sub_reg;
    live_ent_t lm_rdata_reg;

    logic            fm_we;
    logic [FI_W-1:0] fm_waddr;
    free_ent_t       fm_wdata;
    logic [FI_W-1:0] fm_raddr;
    free_ent_t       fm_rd;
    logic            lm_we;
    logic [LI_W-1:0] lm_waddr;
    live_ent_t       lm_wdata;
    logic [LI_W-1:0] lm_raddr;

    logic             cfg_wr;
    logic [1:0]       cfg_idx;
    logic [ALIGN_W-1:0] lg;
    logic [ADDR_W-1:0]  align_bytes;
    logic [ADDR_W-1:0]  align_mask;
    logic [ADDR_W:0]    round_sum;
    logic [ADDR_W-1:0]  round_val;
    logic [FC_W-1:0]    idx_inc;
    logic [FC_W-1:0]    idx_dec;
    logic [FC_W-1:0]    jdx_dec;
    logic [FI_W-1:0]    fidx;
    logic [LI_W-1:0]    lidx;

    assign cfg_wr  = psel & penable & pwrite;
    assign cfg_idx = paddr[PADDR_W-1:3];
    assign pready  = 1'b1;

    // register read back
    always_comb
    begin
        unique case (cfg_idx)
            REG_ARENA_BASE: prdata = PDATA_W'(arena_base_reg);
            REG_ARENA_SIZE: prdata = PDATA_W'(arena_size_reg);
            REG_ALIGN_LOG2: prdata = PDATA_W'(align_log2_reg);
            default:        prdata = '0;
        endcase
    end

    // alignment and rounding
    always_comb
    begin
        if (align_log2_reg < ALIGN_MIN)
            lg = ALIGN_MIN;
        else if (align_log2_reg > ALIGN_MAX)
            lg = ALIGN_MAX;
        else
            lg = align_log2_reg;
    end
    assign align_bytes = ADDR_W'(1) << lg;
    assign align_mask  = align_bytes - ADDR_W'(1);
    assign round_sum   = {1'b0, req_bytes_reg} + {1'b0, align_mask};
    assign round_val   = round_sum[ADDR_W-1:0] & ~align_mask;

    assign idx_inc = idx_reg + FC_W'(1);
    assign idx_dec = idx_reg - FC_W'(1);
    assign jdx_dec = jdx_reg - FC_W'(1);
    assign fidx    = idx_reg[FI_W-1:0];
    assign lidx    = lidx_reg[LI_W-1:0];

    // entry 0 reads as the arena until it is first written
    assign fm_rd = fm_sub_reg ? '{base: arena_base_reg, size: arena_size_reg} : fm_rdata_reg;

    // memory port control
    always_comb
    begin
        fm_we    = 1'b0;
        fm_waddr = fidx;
        fm_wdata = cur_reg;
        fm_raddr = fidx;
        lm_we    = 1'b0;
        lm_waddr = lidx;
        lm_wdata = ent_reg;
        lm_raddr = lidx;
        case (state_reg)
            S_ACOMMIT:
            begin
                lm_we    = 1'b1;
                lm_wdata = '{ident: next_ident_reg, start: cur_reg.base,
                             logical: req_bytes_reg, reserved: need_reg,
                             pin: '0, writable: wr_reg};
                if (cur_reg.size > need_reg)
                begin
                    fm_we    = 1'b1;
                    fm_wdata = '{base: cur_reg.base + need_reg, size: cur_reg.size - need_reg};
                end
            end
            S_SHD_RD:
                fm_raddr = idx_inc[FI_W-1:0];
            S_SHD_WR:
            begin
                fm_we    = 1'b1;
                fm_wdata = fm_rd;
            end
            S_OP:
            begin
                case (func_reg)
                    FN_PIN:
                    begin
                        if (!(pw_reg && !ent_reg.writable) && ent_reg.pin != '1)
                        begin
                            lm_we        = 1'b1;
                            lm_wdata.pin = ent_reg.pin + PIN_BITS'(1);
                        end
                    end
                    FN_UNPIN:
                    begin
                        if (ent_reg.pin != '0)
                        begin
                            lm_we        = 1'b1;
                            lm_wdata.pin = ent_reg.pin - PIN_BITS'(1);
                        end
                    end
                    FN_SEAL:
                    begin
                        if (ent_reg.pin == '0)
                        begin
                            lm_we             = 1'b1;
                            lm_wdata.writable = 1'b0;
                        end
                    end
                    default: ;
                endcase
            end
            S_FR_ACT:
            begin
                if (mp_reg && !mn_reg)
                begin
                    fm_we    = 1'b1;
                    fm_waddr = idx_dec[FI_W-1:0];
                    fm_wdata = '{base: prev_reg.base, size: prev_reg.size + ent_reg.reserved};
                end
                else if (mn_reg && !mp_reg)
                begin
                    fm_we    = 1'b1;
                    fm_wdata = '{base: ent_reg.start, size: cur_reg.size + ent_reg.reserved};
                end
            end
            S_FR_SUM2:
            begin
                fm_we    = 1'b1;
                fm_waddr = idx_dec[FI_W-1:0];
                fm_wdata = '{base: prev_reg.base, size: need_reg + cur_reg.size};
            end
            S_SHU_RD:
                fm_raddr = jdx_dec[FI_W-1:0];
            S_SHU_WR:
            begin
                fm_we    = 1'b1;
                fm_waddr = jdx_reg[FI_W-1:0];
                fm_wdata = fm_rd;
            end
            S_FR_INS:
            begin
                fm_we    = 1'b1;
                fm_wdata = '{base: ent_reg.start, size: ent_reg.reserved};
            end
            default: ;
        endcase
    end

    // free list memory
    always_ff @(posedge clk)
    begin
        if (fm_we)
            free_mem[fm_waddr] <= fm_wdata;
        fm_rdata_reg <= free_mem[fm_raddr];
    end

    // live table memory
    always_ff @(posedge clk)
    begin
        if (lm_we)
            live_mem[lm_waddr] <= lm_wdata;
        lm_rdata_reg <= live_mem[lm_raddr];
    end

    // sequencer, configuration and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            arena_base_reg   <= '0;
            arena_size_reg   <= ARENA_SIZE_RST;
            align_log2_reg   <= ALIGN_MIN;
            count_reg        <= FC_W'(1);
            live_valid_reg   <= '0;
            next_ident_reg   <= ID_W'(1);
            sum_logical_reg  <= '0;
            sum_reserved_reg <= '0;
            peak_reg         <= '0;
            fresh_reg        <= 1'b1;
            fm_sub_reg       <= 1'b0;
            func_reg         <= '0;
            req_bytes_reg    <= '0;
            wr_reg           <= 1'b0;
            pw_reg           <= 1'b0;
            aid_reg          <= '0;
            need_reg         <= '0;
            idx_reg          <= '0;
            jdx_reg          <= '0;
            lidx_reg         <= '0;
            cur_reg          <= '0;
            prev_reg         <= '0;
            ent_reg          <= '0;
            mp_reg           <= 1'b0;
            mn_reg           <= 1'b0;
            res_status_reg   <= ST_OK;
            res_id_reg       <= '0;
            res_base_reg     <= '0;
            res_reserved_reg <= '0;
            out_valid_reg    <= 1'b0;
            out_status_reg   <= '0;
            out_id_reg       <= '0;
            out_base_reg     <= '0;
            out_reserved_reg <= '0;
            out_live_reg     <= '0;
            out_rsv_reg      <= '0;
            out_peak_reg     <= '0;
        end
        else
        begin
            // substitute read data for a read of entry 0 while it is fresh
            fm_sub_reg <= fresh_reg && (fm_raddr == '0);
            if (fm_we && fm_waddr == '0)
                fresh_reg <= 1'b0;

            // result taken; a result handed over in S_DONE reloads the register there
            if (out_valid_reg && !rsp_stall && state_reg != S_DONE)
                out_valid_reg <= 1'b0;

            // configuration writes; the user keeps them to idle, the block does not enforce this
            if (cfg_wr)
            begin
                unique case (cfg_idx)
                    REG_ARENA_BASE:
                    begin
                        arena_base_reg   <= pwdata[ADDR_W-1:0];
                        fresh_reg        <= 1'b1;
                        count_reg        <= FC_W'(arena_size_reg != '0);
                        live_valid_reg   <= '0;
                        sum_logical_reg  <= '0;
                        sum_reserved_reg <= '0;
                    end
                    REG_ARENA_SIZE:
                    begin
                        arena_size_reg   <= pwdata[ADDR_W-1:0];
                        fresh_reg        <= 1'b1;
                        count_reg        <= FC_W'(pwdata[ADDR_W-1:0] != '0);
                        live_valid_reg   <= '0;
                        sum_logical_reg  <= '0;
                        sum_reserved_reg <= '0;
                    end
                    REG_ALIGN_LOG2:
                        align_log2_reg <= pwdata[ALIGN_W-1:0];
                    default: ;
                endcase
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (req_valid)
                    begin
                        func_reg         <= func;
                        req_bytes_reg    <= req_bytes;
                        wr_reg           <= writable_flag;
                        pw_reg           <= pin_for_write;
                        aid_reg          <= alloc_id;
                        res_status_reg   <= ST_OK;
                        res_id_reg       <= '0;
                        res_base_reg     <= '0;
                        res_reserved_reg <= '0;
                        lidx_reg         <= '0;
                        case (func) inside
                            FN_ALLOC:
                                state_reg <= S_NEED;
                            FN_FREE, FN_PIN, FN_UNPIN, FN_SEAL:
                            begin
                                res_id_reg <= alloc_id;
                                if (alloc_id == '0)
                                begin
                                    res_status_reg <= ST_UNKNOWN;
                                    state_reg      <= S_DONE;
                                end
                                else
                                    state_reg <= S_LK_RD;
                            end
                            default:
                                state_reg <= S_DONE;
                        endcase
                    end
                end

                // round up to the alignment, at least one alignment unit
                S_NEED:
                begin
                    if (round_sum[ADDR_W])
                    begin
                        res_status_reg <= ST_TOO_LARGE;
                        state_reg      <= S_DONE;
                    end
                    else
                    begin
                        need_reg  <= (round_val == '0) ? align_bytes : round_val;
                        state_reg <= S_ACHK;
                    end
                end

                S_ACHK:
                begin
                    idx_reg <= '0;
                    if (need_reg > arena_size_reg)
                    begin
                        res_status_reg <= ST_TOO_LARGE;
                        state_reg      <= S_DONE;
                    end
                    else if (next_ident_reg == '0)
                    begin
                        res_status_reg <= ST_ID_EXHAUSTED;
                        state_reg      <= S_DONE;
                    end
                    else
                        state_reg <= S_AF_RD;
                end

                // first-fit scan of the free list
                S_AF_RD:
                begin
                    if (idx_reg >= count_reg)
                    begin
                        res_status_reg <= ST_EXHAUSTED;
                        state_reg      <= S_DONE;
                    end
                    else
                        state_reg <= S_AF_CHK;
                end

                S_AF_CHK:
                begin
                    if (fm_rd.size >= need_reg)
                    begin
                        cur_reg   <= fm_rd;
                        lidx_reg  <= '0;
                        state_reg <= S_SLOT;
                    end
                    else
                    begin
                        idx_reg   <= idx_inc;
                        state_reg <= S_AF_RD;
                    end
                end

                // lowest empty live slot
                S_SLOT:
                begin
                    if (lidx_reg >= LC_W'(MAX_LIVE))
                    begin
                        res_status_reg <= ST_TABLE_FULL;
                        state_reg      <= S_DONE;
                    end
                    else if (!live_valid_reg[lidx])
                        state_reg <= S_ACOMMIT;
                    else
                        lidx_reg <= lidx_reg + LC_W'(1);
                end

                S_ACOMMIT:
                begin
                    live_valid_reg[lidx] <= 1'b1;
                    res_id_reg       <= next_ident_reg;
                    res_base_reg     <= cur_reg.base;
                    res_reserved_reg <= need_reg;
                    next_ident_reg   <= next_ident_reg + ID_W'(1);
                    sum_logical_reg  <= sum_logical_reg + req_bytes_reg;
                    sum_reserved_reg <= sum_reserved_reg + need_reg;
                    if (cur_reg.size > need_reg)
                        state_reg <= S_PEAK;
                    else
                    begin
                        count_reg <= count_reg - FC_W'(1);
                        state_reg <= S_SHD_RD;
                    end
                end

                S_PEAK:
                begin
                    if (sum_reserved_reg > peak_reg)
                        peak_reg <= sum_reserved_reg;
                    state_reg <= S_DONE;
                end

                // close the gap at idx by moving later ranges down
                S_SHD_RD:
                begin
                    if (idx_reg < count_reg)
                        state_reg <= S_SHD_WR;
                    else if (func_reg == FN_ALLOC)
                        state_reg <= S_PEAK;
                    else
                        state_reg <= S_DONE;
                end

                S_SHD_WR:
                begin
                    idx_reg   <= idx_inc;
                    state_reg <= S_SHD_RD;
                end

                // id lookup in the live table
                S_LK_RD:
                begin
                    if (lidx_reg >= LC_W'(MAX_LIVE))
                    begin
                        res_status_reg <= ST_UNKNOWN;
                        state_reg      <= S_DONE;
                    end
                    else if (!live_valid_reg[lidx])
                        lidx_reg <= lidx_reg + LC_W'(1);
                    else
                        state_reg <= S_LK_CHK;
                end

                S_LK_CHK:
                begin
                    if (lm_rdata_reg.ident == aid_reg)
                    begin
                        ent_reg          <= lm_rdata_reg;
                        res_base_reg     <= lm_rdata_reg.start;
                        res_reserved_reg <= lm_rdata_reg.reserved;
                        state_reg        <= S_OP;
                    end
                    else
                    begin
                        lidx_reg  <= lidx_reg + LC_W'(1);
                        state_reg <= S_LK_RD;
                    end
                end

                // act on the found entry
                S_OP:
                begin
                    state_reg <= S_DONE;
                    case (func_reg)
                        FN_FREE:
                        begin
                            if (ent_reg.pin != '0)
                                res_status_reg <= ST_PINNED;
                            else
                            begin
                                idx_reg   <= '0;
                                state_reg <= S_FR_RD;
                            end
                        end
                        FN_PIN:
                        begin
                            if (pw_reg && !ent_reg.writable)
                                res_status_reg <= ST_READ_ONLY;
                            else if (ent_reg.pin == '1)
                                res_status_reg <= ST_PIN_OVERFLOW;
                        end
                        FN_UNPIN:
                        begin
                            if (ent_reg.pin == '0)
                                res_status_reg <= ST_NOT_PINNED;
                        end
                        FN_SEAL:
                        begin
                            if (ent_reg.pin != '0)
                                res_status_reg <= ST_PINNED;
                        end
                        default: ;
                    endcase
                end

                // find the insertion point: first range based above the start
                S_FR_RD:
                begin
                    if (idx_reg >= count_reg)
                        state_reg <= S_FR_MERGE;
                    else
                        state_reg <= S_FR_CHK;
                end

                S_FR_CHK:
                begin
                    if (fm_rd.base <= ent_reg.start)
                    begin
                        prev_reg  <= fm_rd;
                        idx_reg   <= idx_inc;
                        state_reg <= S_FR_RD;
                    end
                    else
                    begin
                        cur_reg   <= fm_rd;
                        state_reg <= S_FR_MERGE;
                    end
                end

                // touching neighbours
                S_FR_MERGE:
                begin
                    mp_reg <= (idx_reg != '0) &&
                              (prev_reg.base + prev_reg.size == ent_reg.start);
                    mn_reg <= (idx_reg < count_reg) &&
                              (ent_reg.start + ent_reg.reserved == cur_reg.base);
                    state_reg <= S_FR_ACT;
                end

                S_FR_ACT:
                begin
                    if (!mp_reg && !mn_reg && count_reg >= FC_W'(MAX_FREE))
                    begin
                        res_status_reg <= ST_TABLE_FULL;
                        state_reg      <= S_DONE;
                    end
                    else
                    begin
                        live_valid_reg[lidx] <= 1'b0;
                        sum_logical_reg  <= sum_logical_reg - ent_reg.logical;
                        sum_reserved_reg <= sum_reserved_reg - ent_reg.reserved;
                        if (mp_reg && mn_reg)
                        begin
                            need_reg  <= prev_reg.size + ent_reg.reserved;
                            state_reg <= S_FR_SUM2;
                        end
                        else if (mp_reg || mn_reg)
                            state_reg <= S_DONE;
                        else
                        begin
                            jdx_reg   <= count_reg;
                            state_reg <= S_SHU_RD;
                        end
                    end
                end

                // both neighbours: widen the lower one, drop the upper one
                S_FR_SUM2:
                begin
                    count_reg <= count_reg - FC_W'(1);
                    state_reg <= S_SHD_RD;
                end

                // open a gap at idx by moving ranges up
                S_SHU_RD:
                begin
                    if (jdx_reg > idx_reg)
                        state_reg <= S_SHU_WR;
                    else
                        state_reg <= S_FR_INS;
                end

                S_SHU_WR:
                begin
                    jdx_reg   <= jdx_dec;
                    state_reg <= S_SHU_RD;
                end

                S_FR_INS:
                begin
                    count_reg <= count_reg + FC_W'(1);
                    state_reg <= S_DONE;
                end

                // hand the result to the output register
                S_DONE:
                begin
                    if (!out_valid_reg || !rsp_stall)
                    begin
                        out_valid_reg    <= 1'b1;
                        out_status_reg   <= res_status_reg;
                        out_id_reg       <= res_id_reg;
                        out_base_reg     <= res_base_reg;
                        out_reserved_reg <= res_reserved_reg;
                        out_live_reg     <= sum_logical_reg;
                        out_rsv_reg      <= sum_reserved_reg;
                        out_peak_reg     <= peak_reg;
                        state_reg        <= S_IDLE;
                    end
                end

                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign req_stall       = (state_reg != S_IDLE);
    assign rsp_valid       = out_valid_reg;
    assign status          = out_status_reg;
    assign result_id       = out_id_reg;
    assign result_base     = out_base_reg;
    assign result_reserved = out_reserved_reg;
    assign live_total      = out_live_reg;
    assign reserved_total  = out_rsv_reg;
    assign peak_total      = out_peak_reg;

    // free list never holds more than its depth
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FC_W'(MAX_FREE))
        else $error("free range count beyond depth");

    // a new allocation only lands in an empty live slot
    a_slot_empty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_ACOMMIT |-> !live_valid_reg[lidx])
        else $error("allocation over a live entry");

    // moving ranges down stays within the list
    a_shift_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SHD_WR |-> idx_reg < count_reg)
        else $error("free list shift past its end");

    // between requests the peak covers the running reserved sum
    a_peak_cover: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> sum_reserved_reg <= peak_reg)
        else $error("reserved sum above peak");

endmodule
`default_nettype wire
